### hdl/ipal_pkg.sv
`default_nettype none

package ipal_pkg;

   // Number of slots in each allow list.
   localparam int ENTRIES = 16;
   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);

   // Command codes on the request channel.
   localparam logic [1:0] CMD_WR_V4 = 2'd0;
   localparam logic [1:0] CMD_WR_V6 = 2'd1;
   localparam logic [1:0] CMD_CHECK = 2'd2;

   // Address family codes for checks.
   localparam logic [1:0] FAM_V4 = 2'd1;
   localparam logic [1:0] FAM_V6 = 2'd2;

   // Configuration register indexes.
   localparam logic REG_V4_COUNT = 1'b0;
   localparam logic REG_V6_COUNT = 1'b1;

   localparam logic [7:0] PLEN_MAX_V4 = 8'd32;
   localparam logic [7:0] PLEN_MAX_V6 = 8'd128;

   // Operation kinds handed from the front end to the back end.
   localparam logic [2:0] OP_WR_V4  = 3'd0;
   localparam logic [2:0] OP_WR_V6  = 3'd1;
   localparam logic [2:0] OP_CHK_V4 = 3'd2;
   localparam logic [2:0] OP_CHK_V6 = 3'd3;
   localparam logic [2:0] OP_ALLOW  = 3'd4;
   localparam logic [2:0] OP_NOP    = 3'd5;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [1:0]  family;
      logic [3:0]  index;
      logic [63:0] addr_hi;
      logic [63:0] addr_lo;
      logic [7:0]  prefix_len;
   } req_type;

   typedef struct packed {
      logic       allowed;
      logic       matched;
      logic [3:0] match_index;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  slot;
      logic [63:0] addr_hi;
      logic [63:0] addr_lo;
      logic [7:0]  plen;
   } op_type;

   function automatic logic [31:0] mask32(input logic [5:0] len);
      return ~(32'hffff_ffff >> len);
   endfunction

   function automatic logic [127:0] mask128(input logic [7:0] len);
      return ~({128{1'b1}} >> len);
   endfunction

endpackage

`default_nettype wire

### hdl/ip_prefix_allow_list_top.sv
// IP prefix allow list: checks client addresses against an IPv4 and an IPv6
// list of address/prefix entries.
// Request channel: a transfer happens when push is high and full is low.
// A request loads an entry (cmd write IPv4 / write IPv6), checks an address
// or is a no-op. Every request gives exactly one response, in request order.
// Response channel: the oldest response is on rsp_data while empty is low; a
// transfer happens when pop is high and empty is low.
// List lengths are set through csr_we / csr_index / csr_data; the user must
// set them only while idle, as the block does not enforce it. Writes, checks
// of another family and checks against an empty list are answered from the
// idle state. While the response queue has room, a scanning check compares
// one entry per cycle against its single entry read, up to the list count.
// Throughput: one request per cycle when no scan runs and the response queue
// has room; a scanning check holds the back end until its scan ends.
// A two-slot request queue and a two-slot response queue decouple the sides;
// if the receiver stalls, the back end halts once the response queue is full
// and full rises once the request queue fills in turn.
// Reset empties both queues and clears both counts; list entries keep no reset
// value and must be written before a check reaches them.
`default_nettype none

module ip_prefix_allow_list_top (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire ipal_pkg::req_type req_data,
   output logic                   empty,
   input  wire logic              pop,
   output ipal_pkg::rsp_type      rsp_data,
   input  wire logic              csr_we,
   input  wire logic              csr_index,
   input  wire logic [4:0]        csr_data
);

   logic             op_valid;
   logic             op_take;
   ipal_pkg::op_type op_data;

   ipal_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .op_valid (op_valid),
      .op_data  (op_data),
      .op_take  (op_take)
   );

   ipal_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .op_valid  (op_valid),
      .op_data   (op_data),
      .op_take   (op_take),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### hdl/ipal_front.sv
`default_nettype none

module ipal_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire ipal_pkg::req_type req_data,
   output logic                  op_valid,
   output ipal_pkg::op_type      op_data,
   input  wire logic             op_take
);

   ipal_pkg::op_type q_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   ipal_pkg::op_type op_in;
   logic             do_push, do_pop;

   // Decode and prefix saturation happen before the item enters the queue.
   always_comb begin
      op_in.slot    = req_data.index;
      op_in.addr_hi = req_data.addr_hi;
      op_in.addr_lo = req_data.addr_lo;
      op_in.plen    = req_data.prefix_len;
      case (req_data.cmd)
         ipal_pkg::CMD_WR_V4: begin
            op_in.kind = ipal_pkg::OP_WR_V4;
            if (req_data.prefix_len > ipal_pkg::PLEN_MAX_V4) begin
               op_in.plen = ipal_pkg::PLEN_MAX_V4;
            end
         end
         ipal_pkg::CMD_WR_V6: begin
            op_in.kind = ipal_pkg::OP_WR_V6;
            if (req_data.prefix_len > ipal_pkg::PLEN_MAX_V6) begin
               op_in.plen = ipal_pkg::PLEN_MAX_V6;
            end
         end
         ipal_pkg::CMD_CHECK: begin
            case (req_data.family)
               ipal_pkg::FAM_V4: op_in.kind = ipal_pkg::OP_CHK_V4;
               ipal_pkg::FAM_V6: op_in.kind = ipal_pkg::OP_CHK_V6;
               default:          op_in.kind = ipal_pkg::OP_ALLOW;
            endcase
         end
         default: op_in.kind = ipal_pkg::OP_NOP;
      endcase
   end

   assign full     = (cnt_ff == 2'd2);
   assign op_valid = (cnt_ff != 2'd0);
   assign op_data  = q_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = op_take && op_valid;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= op_in;
      end
   end

endmodule

`default_nettype wire

### hdl/ipal_back.sv
`default_nettype none

module ipal_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic              csr_index,
   input  wire logic [4:0]        csr_data,
   input  wire logic              op_valid,
   input  wire ipal_pkg::op_type  op_data,
   output logic                   op_take,
   output logic                   empty,
   input  wire logic              pop,
   output ipal_pkg::rsp_type      rsp_data
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   localparam int IW = ipal_pkg::IDX_W;
   localparam int CW = ipal_pkg::CNT_W;

   // No-reset entry flops; user must have slots written before read, unenforced.
   logic [31:0]  v4_addr_ff [ipal_pkg::ENTRIES];
   logic [5:0]   v4_len_ff  [ipal_pkg::ENTRIES];
   logic [63:0]  v6_hi_ff   [ipal_pkg::ENTRIES];
   logic [63:0]  v6_lo_ff   [ipal_pkg::ENTRIES];
   logic [7:0]   v6_len_ff  [ipal_pkg::ENTRIES];

   logic [4:0]   v4_count_ff, v6_count_ff;
   logic         state_ff, state_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] n_v4, n_v6;
   logic         scan_v6_ff, scan_v6_in;
   logic [63:0]  scan_hi_ff, scan_hi_in;
   logic [63:0]  scan_lo_ff, scan_lo_in;

   ipal_pkg::rsp_type res_q_ff [2];
   logic         res_wr_ff, res_rd_ff;
   logic [1:0]   res_cnt_ff, res_cnt_in;
   logic         res_push, res_pop, res_room;
   ipal_pkg::rsp_type res_in;

   logic         wr_v4, wr_v6, slot_ok;
   logic [IW-1:0] wr_idx;
   logic         hit_v4, hit_v6, hit, last;

   always_comb begin
      n_v4 = (32'(v4_count_ff) > ipal_pkg::ENTRIES) ?
             CW'(ipal_pkg::ENTRIES) : CW'(v4_count_ff);
      n_v6 = (32'(v6_count_ff) > ipal_pkg::ENTRIES) ?
             CW'(ipal_pkg::ENTRIES) : CW'(v6_count_ff);
   end

   assign slot_ok = (32'(op_data.slot) < ipal_pkg::ENTRIES);
   assign wr_idx  = IW'(op_data.slot);

   // One entry is compared per cycle while scanning and the result queue has room.
   assign hit_v4 = (((scan_lo_ff[31:0] ^ v4_addr_ff[idx_ff]) &
                     ipal_pkg::mask32(v4_len_ff[idx_ff])) == 32'd0);
   assign hit_v6 = ((({scan_hi_ff, scan_lo_ff} ^ {v6_hi_ff[idx_ff], v6_lo_ff[idx_ff]}) &
                     ipal_pkg::mask128(v6_len_ff[idx_ff])) == 128'd0);
   assign hit    = scan_v6_ff ? hit_v6 : hit_v4;
   assign last   = ((CW'(idx_ff) + CW'(1)) == n_ff);

   assign res_room = (res_cnt_ff != 2'd2);

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      n_in       = n_ff;
      scan_v6_in = scan_v6_ff;
      scan_hi_in = scan_hi_ff;
      scan_lo_in = scan_lo_ff;
      op_take    = 1'b0;
      res_push   = 1'b0;
      res_in     = '0;
      wr_v4      = 1'b0;
      wr_v6      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (op_valid && res_room) begin
               op_take = 1'b1;
               case (op_data.kind)
                  ipal_pkg::OP_WR_V4: begin
                     wr_v4    = slot_ok;
                     res_push = 1'b1;
                  end
                  ipal_pkg::OP_WR_V6: begin
                     wr_v6    = slot_ok;
                     res_push = 1'b1;
                  end
                  ipal_pkg::OP_ALLOW: begin
                     res_push       = 1'b1;
                     res_in.allowed = 1'b1;
                  end
                  ipal_pkg::OP_CHK_V4, ipal_pkg::OP_CHK_V6: begin
                     scan_v6_in = (op_data.kind == ipal_pkg::OP_CHK_V6);
                     n_in       = scan_v6_in ? n_v6 : n_v4;
                     scan_hi_in = op_data.addr_hi;
                     scan_lo_in = op_data.addr_lo;
                     idx_in     = '0;
                     if (n_in == '0) begin
                        // An empty list lets every address of its family through.
                        res_push       = 1'b1;
                        res_in.allowed = 1'b1;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                     res_push = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (res_room) begin
               if (hit) begin
                  res_push           = 1'b1;
                  res_in.allowed     = 1'b1;
                  res_in.matched     = 1'b1;
                  res_in.match_index = 4'(idx_ff);
                  state_in           = ST_IDLE;
               end else if (last) begin
                  res_push = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + IW'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         v4_count_ff <= 5'd0;
         v6_count_ff <= 5'd0;
      end else begin
         state_ff <= state_in;
         if (csr_we && (csr_index == ipal_pkg::REG_V4_COUNT)) begin
            v4_count_ff <= csr_data;
         end
         if (csr_we && (csr_index == ipal_pkg::REG_V6_COUNT)) begin
            v6_count_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      n_ff       <= n_in;
      scan_v6_ff <= scan_v6_in;
      scan_hi_ff <= scan_hi_in;
      scan_lo_ff <= scan_lo_in;
      if (wr_v4) begin
         v4_addr_ff[wr_idx] <= op_data.addr_lo[31:0];
         v4_len_ff[wr_idx]  <= op_data.plen[5:0];
      end
      if (wr_v6) begin
         v6_hi_ff[wr_idx]  <= op_data.addr_hi;
         v6_lo_ff[wr_idx]  <= op_data.addr_lo;
         v6_len_ff[wr_idx] <= op_data.plen;
      end
   end

   // Result queue: two slots, so a scan can finish while the receiver stalls.
   assign empty      = (res_cnt_ff == 2'd0);
   assign rsp_data   = res_q_ff[res_rd_ff];
   assign res_pop    = pop && !empty;
   assign res_cnt_in = res_cnt_ff + {1'b0, res_push} - {1'b0, res_pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         res_wr_ff  <= 1'b0;
         res_rd_ff  <= 1'b0;
         res_cnt_ff <= 2'd0;
      end else begin
         res_cnt_ff <= res_cnt_in;
         if (res_push) begin
            res_wr_ff <= ~res_wr_ff;
         end
         if (res_pop) begin
            res_rd_ff <= ~res_rd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (res_push) begin
         res_q_ff[res_wr_ff] <= res_in;
      end
   end

   a_scan_in_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (CW'(idx_ff) < n_ff))
      else $error("scan index beyond the list count");

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      res_push |-> (res_cnt_ff != 2'd2))
      else $error("result pushed into a full queue");

   a_take_when_idle : assert property (@(posedge clock) disable iff (reset)
      op_take |-> (state_ff == ST_IDLE))
      else $error("operation taken during a scan");

   a_match_allows : assert property (@(posedge clock) disable iff (reset)
      (res_push && res_in.matched) |-> res_in.allowed)
      else $error("matched result not allowed");

   a_scan_ends : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && res_room && (hit || last)) |=> (state_ff == ST_IDLE))
      else $error("scan did not finish after its final entry");

endmodule

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [1:0] FAM_NONE = 2'd0;
   localparam logic [1:0] FAM_OTHER = 2'd3;
   localparam logic [63:0] ONES64 = '1;
   localparam ipal_pkg::rsp_type NO_DECISION = 6'b0;
   localparam ipal_pkg::rsp_type DENIED = 6'b0;
   localparam ipal_pkg::rsp_type ALLOW_BY_DEFAULT = {1'b1, 1'b0, 4'd0};
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 64;

   typedef struct {
      bit                set_counts;
      logic [4:0]        v4n;
      logic [4:0]        v6n;
      ipal_pkg::req_type item;
      bit                fixed;
      ipal_pkg::rsp_type want;
   } plan_row_type;

   logic              clock;
   logic              reset;
   logic              push;
   logic              full;
   ipal_pkg::req_type req_data;
   logic              empty;
   logic              pop;
   ipal_pkg::rsp_type rsp_data;
   logic              csr_we;
   logic              csr_index;
   logic [4:0]        csr_data;

   // Shadow of the allow lists and their lengths.
   logic [31:0]  acl_v4_addr [ipal_pkg::ENTRIES];
   logic [5:0]   acl_v4_plen [ipal_pkg::ENTRIES];
   logic [127:0] acl_v6_addr [ipal_pkg::ENTRIES];
   logic [7:0]   acl_v6_plen [ipal_pkg::ENTRIES];
   logic [4:0]   acl_v4_count;
   logic [4:0]   acl_v6_count;

   ipal_pkg::rsp_type pending_decisions[$];
   plan_row_type      directed_plan[$];
   int                error_count = 0;
   int                push_idle_pct = 0;
   int                pop_stall_pct = 0;
   bit                use_fixed = 1'b0;
   ipal_pkg::rsp_type fixed_decision = NO_DECISION;

   ip_prefix_allow_list_top u_top (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [31:0] v4_mask(input logic [5:0] len);
      return {32{1'b1}} << (32 - len);
   endfunction

   function automatic logic [127:0] v6_mask(input logic [7:0] len);
      return {128{1'b1}} << (128 - len);
   endfunction

   // Works out the decision for one request from the current list contents.
   function automatic ipal_pkg::rsp_type access_decision(input ipal_pkg::req_type r);
      ipal_pkg::rsp_type d;
      int                n;
      logic [127:0]      a6;
      d = NO_DECISION;
      if (r.cmd == ipal_pkg::CMD_CHECK) begin
         d.allowed = 1'b1;
         if (r.family == ipal_pkg::FAM_V4 && acl_v4_count != 0) begin
            n = (acl_v4_count > ipal_pkg::ENTRIES) ? ipal_pkg::ENTRIES : int'(acl_v4_count);
            d.allowed = 1'b0;
            for (int i = 0; i < n; i++) begin
               if (!d.matched &&
                   ((r.addr_lo[31:0] ^ acl_v4_addr[i]) & v4_mask(acl_v4_plen[i])) == 0) begin
                  d.allowed = 1'b1;
                  d.matched = 1'b1;
                  d.match_index = i[3:0];
               end
            end
         end else if (r.family == ipal_pkg::FAM_V6 && acl_v6_count != 0) begin
            n = (acl_v6_count > ipal_pkg::ENTRIES) ? ipal_pkg::ENTRIES : int'(acl_v6_count);
            a6 = {r.addr_hi, r.addr_lo};
            d.allowed = 1'b0;
            for (int i = 0; i < n; i++) begin
               if (!d.matched &&
                   ((a6 ^ acl_v6_addr[i]) & v6_mask(acl_v6_plen[i])) == 0) begin
                  d.allowed = 1'b1;
                  d.matched = 1'b1;
                  d.match_index = i[3:0];
               end
            end
         end
      end
      return d;
   endfunction

   // Loads an entry into the shadow lists; prefix lengths saturate on the way in.
   function automatic void store_entry(input ipal_pkg::req_type r);
      if (r.cmd == ipal_pkg::CMD_WR_V4) begin
         acl_v4_addr[r.index] = r.addr_lo[31:0];
         acl_v4_plen[r.index] = (r.prefix_len > ipal_pkg::PLEN_MAX_V4) ?
                                6'(ipal_pkg::PLEN_MAX_V4) : r.prefix_len[5:0];
      end else if (r.cmd == ipal_pkg::CMD_WR_V6) begin
         acl_v6_addr[r.index] = {r.addr_hi, r.addr_lo};
         acl_v6_plen[r.index] = (r.prefix_len > ipal_pkg::PLEN_MAX_V6) ?
                                ipal_pkg::PLEN_MAX_V6 : r.prefix_len;
      end
   endfunction

   // Most checks take an address built around a stored entry, so that matches,
   // near misses and scans past several entries all occur often.
   function automatic ipal_pkg::req_type random_request(input logic [1:0] cmd);
      ipal_pkg::req_type r;
      int                roll;
      int                k;
      int                b;
      logic [31:0]       m4;
      logic [127:0]      m6;
      logic [127:0]      a6;
      r.cmd = cmd;
      roll = $urandom_range(99);
      r.family = (roll < 45) ? ipal_pkg::FAM_V4 : (roll < 90) ? ipal_pkg::FAM_V6 :
                 (roll < 95) ? FAM_NONE : FAM_OTHER;
      r.index = 4'($urandom_range(ipal_pkg::ENTRIES - 1));
      r.addr_hi = {$urandom, $urandom};
      r.addr_lo = {$urandom, $urandom};
      if ($urandom_range(99) < 30) begin
         r.prefix_len = 8'($urandom_range(255));
      end else if (cmd == ipal_pkg::CMD_WR_V4) begin
         r.prefix_len = 8'($urandom_range(32));
      end else begin
         r.prefix_len = 8'($urandom_range(128));
      end
      k = $urandom_range(ipal_pkg::ENTRIES - 1);
      if (cmd == ipal_pkg::CMD_CHECK && $urandom_range(99) < 70) begin
         if (r.family == ipal_pkg::FAM_V4) begin
            m4 = v4_mask(acl_v4_plen[k]);
            r.addr_lo[31:0] = (acl_v4_addr[k] & m4) | (r.addr_lo[31:0] & ~m4);
            if ($urandom_range(3) == 0) begin
               b = $urandom_range(31);
               r.addr_lo[b] = ~r.addr_lo[b];
            end
         end else if (r.family == ipal_pkg::FAM_V6) begin
            m6 = v6_mask(acl_v6_plen[k]);
            a6 = (acl_v6_addr[k] & m6) | ({r.addr_hi, r.addr_lo} & ~m6);
            if ($urandom_range(3) == 0) begin
               b = $urandom_range(127);
               a6[b] = ~a6[b];
            end
            {r.addr_hi, r.addr_lo} = a6;
         end
      end
      return r;
   endfunction

   function automatic void add_req(input logic [1:0] cmd, input logic [1:0] fam,
                                   input logic [3:0] idx, input logic [63:0] hi,
                                   input logic [63:0] lo, input logic [7:0] plen,
                                   input bit fixed, input ipal_pkg::rsp_type want);
      plan_row_type row;
      row.set_counts = 1'b0;
      row.v4n = '0;
      row.v6n = '0;
      row.item = {cmd, fam, idx, hi, lo, plen};
      row.fixed = fixed;
      row.want = want;
      directed_plan.push_back(row);
   endfunction

   function automatic void add_counts(input logic [4:0] v4n, input logic [4:0] v6n);
      plan_row_type row;
      row.set_counts = 1'b1;
      row.v4n = v4n;
      row.v6n = v6n;
      row.item = '0;
      row.fixed = 1'b0;
      row.want = NO_DECISION;
      directed_plan.push_back(row);
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_req(input ipal_pkg::req_type item, input bit fixed,
                           input ipal_pkg::rsp_type want);
      while ($urandom_range(99) < push_idle_pct) begin
         push <= 1'b0;
         @(negedge clock);
      end
      use_fixed = fixed;
      fixed_decision = want;
      push <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (full) @(posedge clock);
      @(negedge clock);
   endtask

   // List lengths change only once every outstanding decision has come back
   // and the longest scan has had time to finish.
   task automatic write_counts(input logic [4:0] v4n, input logic [4:0] v6n);
      push <= 1'b0;
      while (pending_decisions.size() != 0) @(negedge clock);
      repeat (24) @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= ipal_pkg::REG_V4_COUNT;
      csr_data <= v4n;
      @(negedge clock);
      csr_index <= ipal_pkg::REG_V6_COUNT;
      csr_data <= v6n;
      @(negedge clock);
      csr_we <= 1'b0;
      acl_v4_count = v4n;
      acl_v6_count = v6n;
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      pop <= ($urandom_range(99) >= pop_stall_pct);
   end

   always @(posedge clock) begin : monitor
      ipal_pkg::rsp_type want;
      if (!reset) begin
         if (push && !full) begin
            want = access_decision(req_data);
            if (use_fixed) begin
               want = fixed_decision;
            end
            pending_decisions.push_back(want);
            store_entry(req_data);
         end
         if (pop && !empty) begin
            if (pending_decisions.size() == 0) begin
               $error("response transfer with no request outstanding: %h", rsp_data);
               error_count++;
            end else begin
               want = pending_decisions.pop_front();
               if (rsp_data.allowed !== want.allowed) begin
                  $error("allowed: expected %0d, actual %0d", want.allowed, rsp_data.allowed);
                  error_count++;
               end
               if (rsp_data.matched !== want.matched) begin
                  $error("matched: expected %0d, actual %0d", want.matched, rsp_data.matched);
                  error_count++;
               end
               if (rsp_data.match_index !== want.match_index) begin
                  $error("match_index: expected %0d, actual %0d",
                         want.match_index, rsp_data.match_index);
                  error_count++;
               end
            end
         end
      end
   end

   initial begin
      logic [4:0]        phase_v4 [PHASES];
      logic [4:0]        phase_v6 [PHASES];
      ipal_pkg::req_type item;
      logic [1:0]        cmd;
      int                roll;
      phase_v4 = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd16, 5'd8, 5'd5, 5'd31};
      phase_v6 = '{5'd16, 5'd1, 5'd31, 5'd16, 5'd0, 5'd16, 5'd12, 5'd31};
      reset = 1'b1;
      push = 1'b0;
      pop = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = ipal_pkg::REG_V4_COUNT;
      csr_data = '0;
      acl_v4_count = '0;
      acl_v6_count = '0;

      // Empty lists allow everything; writes and the unused command decide nothing.
      add_req(ipal_pkg::CMD_CHECK, ipal_pkg::FAM_V4, 4'd0, 64'h0, 64'h0, 8'd0,
              1'b1, ALLOW_BY_DEFAULT);
      add_req(ipal_pkg::CMD_CHECK, ipal_pkg::FAM_V6, 4'd15, ONES64, ONES64, 8'd255,
              1'b1, ALLOW_BY_DEFAULT);
      add_req(ipal_pkg::CMD_CHECK, FAM_NONE, 4'd0, ONES64, ONES64, 8'd0,
              1'b1, ALLOW_BY_DEFAULT);
      add_req(ipal_pkg::CMD_CHECK, FAM_OTHER, 4'd15, 64'h0, 64'h0, 8'd255,
              1'b1, ALLOW_BY_DEFAULT);
      add_req(CMD_UNUSED, FAM_OTHER, 4'd15, ONES64, ONES64, 8'd255, 1'b1, NO_DECISION);
      add_req(ipal_pkg::CMD_WR_V4, FAM_NONE, 4'd0, 64'h0, 64'h0a00_0000, 8'd8,
              1'b1, NO_DECISION);
      // The upper address bits are ignored and the prefix saturates to a full match.
      add_req(ipal_pkg::CMD_WR_V4, FAM_OTHER, 4'd1, ONES64, 64'hffff_ffff_c0a8_0100, 8'd200,
              1'b1, NO_DECISION);
      add_req(ipal_pkg::CMD_WR_V4, ipal_pkg::FAM_V4, 4'd2, 64'h0, 64'h1234_5678, 8'd0,
              1'b1, NO_DECISION);
      add_req(ipal_pkg::CMD_WR_V6, FAM_NONE, 4'd0, 64'h2001_0db8_0000_0000, 64'h0, 8'd32,
              1'b1, NO_DECISION);
      add_req(ipal_pkg::CMD_WR_V6, ipal_pkg::FAM_V6, 4'd1, ONES64, ONES64, 8'd255,
              1'b1, NO_DECISION);
      add_req(ipal_pkg::CMD_WR_V6, ipal_pkg::FAM_V4, 4'd2, 64'hdead_beef, 64'h5, 8'd0,
              1'b1, NO_DECISION);
      add_counts(5'd2, 5'd2);
      add_req(ipal_pkg::CMD_CHECK, ipal_pkg::FAM_V4, 4'd0, 64'h0, 64'h0a01_0203, 8'd0,
              1'b1, {2'b11, 4'd0});
      add_req(ipal_pkg::CMD_CHECK, ipal_pkg::FAM_V4, 4'd0, ONES64, 64'hffff_ffff_c0a8_0100,
              8'd0, 1'b1, {2'b11, 4'd1});
      add_req(ipal_pkg::CMD_CHECK, ipal_pkg::FAM_V4, 4'd0, 64'h0, 64'hc0a8_0101, 8'd0,
              1'b1, DENIED);
      add_req(ipal_pkg::CMD_CHECK, ipal_pkg::FAM_V6, 4'd0, 64'h2001_0db8_ffff_0000, ONES64,
              8'd0, 1'b1, {2'b11, 4'd0});
      add_req(ipal_pkg::CMD_CHECK, ipal_pkg::FAM_V6, 4'd0, ONES64, ONES64, 8'd0,
              1'b1, {2'b11, 4'd1});
      add_req(ipal_pkg::CMD_CHECK, ipal_pkg::FAM_V6, 4'd0, ONES64, 64'hffff_ffff_ffff_fffe,
              8'd0, 1'b1, DENIED);
      add_counts(5'd3, 5'd3);
      // A zero prefix in the third slot catches whatever the first two miss.
      add_req(ipal_pkg::CMD_CHECK, ipal_pkg::FAM_V4, 4'd0, 64'h0, 64'hc0a8_0101, 8'd0,
              1'b1, {2'b11, 4'd2});
      add_req(ipal_pkg::CMD_CHECK, ipal_pkg::FAM_V6, 4'd0, 64'h0, 64'h1, 8'd0,
              1'b1, {2'b11, 4'd2});
      add_req(ipal_pkg::CMD_CHECK, FAM_NONE, 4'd0, 64'h0, 64'h0a00_0001, 8'd0,
              1'b1, ALLOW_BY_DEFAULT);
      add_req(ipal_pkg::CMD_CHECK, ipal_pkg::FAM_V4, 4'd7, 64'h0, 64'h0aff_ffff, 8'd255,
              1'b0, NO_DECISION);
      add_req(ipal_pkg::CMD_WR_V4, ipal_pkg::FAM_V4, 4'd0, ONES64, 64'hffff_ffff_0a00_0000,
              8'd33, 1'b0, NO_DECISION);
      add_req(ipal_pkg::CMD_CHECK, ipal_pkg::FAM_V4, 4'd0, 64'h0, 64'h0a00_0001, 8'd0,
              1'b0, NO_DECISION);

      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      push_idle_pct = 20;
      pop_stall_pct = 20;
      foreach (directed_plan[i]) begin
         if (directed_plan[i].set_counts) begin
            write_counts(directed_plan[i].v4n, directed_plan[i].v6n);
         end else begin
            send_req(directed_plan[i].item, directed_plan[i].fixed, directed_plan[i].want);
         end
      end

      // Every slot of both lists is loaded before any longer list is scanned.
      push_idle_pct = 0;
      pop_stall_pct = 0;
      for (int s = 0; s < ipal_pkg::ENTRIES; s++) begin
         item = random_request(ipal_pkg::CMD_WR_V4);
         item.index = s[3:0];
         send_req(item, 1'b0, NO_DECISION);
         item = random_request(ipal_pkg::CMD_WR_V6);
         item.index = s[3:0];
         send_req(item, 1'b0, NO_DECISION);
      end

      for (int p = 0; p < PHASES; p++) begin
         write_counts(phase_v4[p], phase_v6[p]);
         case (p % 4)
            0: begin
               push_idle_pct = 0;
               pop_stall_pct = 0;
            end
            1: begin
               push_idle_pct = 49;
               pop_stall_pct = 0;
            end
            2: begin
               push_idle_pct = 0;
               pop_stall_pct = 49;
            end
            default: begin
               push_idle_pct = 30;
               pop_stall_pct = 30;
            end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(99);
            cmd = (roll < 12) ? ipal_pkg::CMD_WR_V4 : (roll < 24) ? ipal_pkg::CMD_WR_V6 :
                  (roll < 27) ? CMD_UNUSED : ipal_pkg::CMD_CHECK;
            send_req(random_request(cmd), 1'b0, NO_DECISION);
         end
      end

      push <= 1'b0;
      while (pending_decisions.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (error_count == 0) begin
         $display("ip_prefix_allow_list_top test passed");
      end else begin
         $display("ip_prefix_allow_list_top test failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("ip_prefix_allow_list_top test failed");
      $finish;
   end

endmodule

### filelist.f
hdl/ipal_pkg.sv
hdl/ipal_front.sv
hdl/ipal_back.sv
hdl/ip_prefix_allow_list_top.sv
sim/tb_top.sv
